FILE: rtl/core/stnm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stnm_pkg: shared widths and types for the sphere triangle node map
// Holds the fixed field widths, the scaled-vector widths and the bundle
// that carries the sign and flag bits along the pipeline.
// ----------------------------------------------------------------------------
package stnm_pkg;
	localparam int unsigned REF_WIDTH  = 32;
	localparam int unsigned OUT_WIDTH  = 32;
	localparam int unsigned FRAC_ONE   = 30;
	localparam int unsigned U_WIDTH    = 31;   // scaled magnitude, at most 2^30
	localparam int unsigned SUM_WIDTH  = 63;   // sum of three squares
	localparam int unsigned LEN_WIDTH  = 32;   // integer square root of the sum
	localparam int unsigned NUM_WIDTH  = U_WIDTH + FRAC_ONE;
	localparam int unsigned QUO_WIDTH  = FRAC_ONE + 1;

	// sign and flag bits that travel with each node
	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
		logic       last;
	} stnm_tag_t;
endpackage

FILE: rtl/core/stnm_affine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stnm_affine: exact affine combination of the three vertices
// Forms Q = -(r+s)*va + (2^30+r)*vb + (2^30+s)*vc per axis over two stages:
// the nine weighted products are registered at full width, then summed.
// ----------------------------------------------------------------------------
module stnm_affine #(
	parameter int unsigned COORD_WIDTH = 32,
	parameter int unsigned Q_WIDTH     = 84
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [2:0][2:0][COORD_WIDTH-1:0] vert,
	input  logic signed [stnm_pkg::REF_WIDTH-1:0] ref_r,
	input  logic signed [stnm_pkg::REF_WIDTH-1:0] ref_s,
	input  logic                                  last_in,
	output logic                                  out_valid,
	output logic signed [2:0][Q_WIDTH-1:0]        q,
	output logic                                  last_out
);
	import stnm_pkg::*;

	localparam int unsigned W_WIDTH = REF_WIDTH + 2;
	localparam int unsigned P_WIDTH = W_WIDTH + COORD_WIDTH;

	logic signed [W_WIDTH-1:0] wt [3];
	logic signed [P_WIDTH-1:0] prod_s1 [3][3];
	logic                      valid_s1;
	logic                      last_s1;

	// form the three weights
	always_comb begin
		wt[0] = -($signed({{2{ref_r[REF_WIDTH-1]}}, ref_r})
			+ $signed({{2{ref_s[REF_WIDTH-1]}}, ref_s}));
		wt[1] = $signed(W_WIDTH'(1) << FRAC_ONE) + $signed({{2{ref_r[REF_WIDTH-1]}}, ref_r});
		wt[2] = $signed(W_WIDTH'(1) << FRAC_ONE) + $signed({{2{ref_s[REF_WIDTH-1]}}, ref_s});
	end

	// stage 1: register the nine weighted products
	always_ff @(posedge clk) begin
		for (int v = 0; v < 3; v++) begin
			for (int a = 0; a < 3; a++) begin
				prod_s1[v][a] <= P_WIDTH'(wt[v]) * P_WIDTH'($signed(vert[v][a]));
			end
		end
		last_s1 <= last_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end

	// stage 2: sum per axis
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			q[a] <= Q_WIDTH'(prod_s1[0][a]) + Q_WIDTH'(prod_s1[1][a]) + Q_WIDTH'(prod_s1[2][a]);
		end
		last_out <= last_s1;
	end
endmodule

FILE: rtl/core/stnm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stnm_scale: block scaling of the affine point
// Takes magnitudes, finds the bit length of the largest one and shifts all
// three so that the largest lands at bit length 30, truncating.
// ----------------------------------------------------------------------------
module stnm_scale #(
	parameter int unsigned Q_WIDTH = 84
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic signed [2:0][Q_WIDTH-1:0]        q,
	input  logic                                  last_in,
	output logic                                  out_valid,
	output logic [2:0][stnm_pkg::U_WIDTH-1:0]     u,
	output stnm_pkg::stnm_tag_t                   tag
);
	import stnm_pkg::*;

	localparam int unsigned BL_WIDTH = $clog2(Q_WIDTH + 1);

	logic [2:0][Q_WIDTH-1:0] mag_s1;
	logic [Q_WIDTH-1:0]      orall_s1;
	logic [2:0]              neg_s1;
	logic                    last_s1;
	logic                    valid_s1;
	logic [BL_WIDTH-1:0]     blen;
	logic [2:0][Q_WIDTH-1:0] mag_c;

	// magnitudes and their OR, which has the same bit length as the max
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mag_c[a] = q[a][Q_WIDTH-1] ? Q_WIDTH'(-q[a]) : Q_WIDTH'(q[a]);
		end
	end

	always_ff @(posedge clk) begin
		mag_s1   <= mag_c;
		orall_s1 <= mag_c[0] | mag_c[1] | mag_c[2];
		for (int a = 0; a < 3; a++) neg_s1[a] <= q[a][Q_WIDTH-1];
		last_s1  <= last_in;
	end

	// bit length of the largest magnitude
	always_comb begin
		blen = '0;
		for (int i = 0; i < Q_WIDTH; i++) begin
			if (orall_s1[i]) blen = BL_WIDTH'(i + 1);
		end
	end

	// shift to the common scale
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (blen > BL_WIDTH'(FRAC_ONE)) begin
				u[a] <= U_WIDTH'(mag_s1[a] >> (blen - BL_WIDTH'(FRAC_ONE)));
			end else begin
				u[a] <= U_WIDTH'(mag_s1[a] << (BL_WIDTH'(FRAC_ONE) - blen));
			end
		end
		tag.neg   <= neg_s1;
		tag.degen <= (orall_s1 == '0);
		tag.last  <= last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1  <= in_valid;
			out_valid <= valid_s1;
		end
	end
endmodule

FILE: rtl/core/stnm_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stnm_sqrt: sum of squares and pipelined integer square root
// One register stage for the squares, one for the sum, then one result bit
// of the restoring square root per stage. The vector and tag ride along.
// ----------------------------------------------------------------------------
module stnm_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [2:0][stnm_pkg::U_WIDTH-1:0] u_in,
	input  stnm_pkg::stnm_tag_t               tag_in,
	output logic                              out_valid,
	output logic [2:0][stnm_pkg::U_WIDTH-1:0] u_out,
	output stnm_pkg::stnm_tag_t               tag_out,
	output logic [stnm_pkg::LEN_WIDTH-1:0]    len
);
	import stnm_pkg::*;

	localparam int unsigned NSTEP = LEN_WIDTH;
	localparam int unsigned RW    = SUM_WIDTH + 2;

	logic [2:0][SUM_WIDTH-1:0] sq_s1;
	logic [2:0][U_WIDTH-1:0]   u_s1;
	stnm_tag_t                 tag_s1;
	logic                      valid_s1;

	logic [SUM_WIDTH-1:0]      sum_s2;
	logic [2:0][U_WIDTH-1:0]   u_s2;
	stnm_tag_t                 tag_s2;
	logic                      valid_s2;

	// per-step root pipeline
	logic [NSTEP:0][2*LEN_WIDTH-1:0] rad_p;
	logic [NSTEP:0][RW-1:0]          rem_p;
	logic [NSTEP:0][LEN_WIDTH-1:0]   root_p;
	logic [NSTEP:0][2:0][U_WIDTH-1:0] u_p;
	stnm_tag_t [NSTEP:0]             tag_p;
	logic [NSTEP:0]                  valid_p;

	// squares and sum
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) sq_s1[a] <= SUM_WIDTH'(u_in[a]) * SUM_WIDTH'(u_in[a]);
		u_s1   <= u_in;
		tag_s1 <= tag_in;
		sum_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		u_s2   <= u_s1;
		tag_s2 <= tag_s1;
	end

	always_comb begin
		rad_p[0]   = {1'b0, sum_s2};
		rem_p[0]   = '0;
		root_p[0]  = '0;
		u_p[0]     = u_s2;
		tag_p[0]   = tag_s2;
		valid_p[0] = valid_s2;
	end

	// one root bit per stage: bring down two radicand bits, try 4*root+1
	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		logic [RW-1:0] rem_sh;
		logic [RW-1:0] trial;
		assign rem_sh = {rem_p[k][RW-3:0], rad_p[k][2*LEN_WIDTH-1 -: 2]};
		assign trial  = RW'({root_p[k], 2'b01});
		always_ff @(posedge clk) begin
			if (rem_sh >= trial) begin
				rem_p[k+1]  <= rem_sh - trial;
				root_p[k+1] <= {root_p[k][LEN_WIDTH-2:0], 1'b1};
			end else begin
				rem_p[k+1]  <= rem_sh;
				root_p[k+1] <= {root_p[k][LEN_WIDTH-2:0], 1'b0};
			end
			rad_p[k+1] <= {rad_p[k][2*LEN_WIDTH-3:0], 2'b00};
			u_p[k+1]   <= u_p[k];
			tag_p[k+1] <= tag_p[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_p[k+1] <= 1'b0;
			else         valid_p[k+1] <= valid_p[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_p[NSTEP];
	assign u_out     = u_p[NSTEP];
	assign tag_out   = tag_p[NSTEP];
	assign len       = root_p[NSTEP];
endmodule

FILE: rtl/core/stnm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stnm_div: pipelined restoring divide of u*2^30 by the length
// Three lanes share each stage; one quotient bit per stage, then sign and
// degenerate handling in a final output register.
// ----------------------------------------------------------------------------
module stnm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic [2:0][stnm_pkg::U_WIDTH-1:0]   u,
	input  stnm_pkg::stnm_tag_t                 tag_in,
	input  logic [stnm_pkg::LEN_WIDTH-1:0]      len,
	output logic                                out_valid,
	output logic signed [2:0][stnm_pkg::OUT_WIDTH-1:0] unit,
	output logic                                degenerate,
	output logic                                last_out
);
	import stnm_pkg::*;

	localparam int unsigned NSTEP = QUO_WIDTH;
	localparam int unsigned RW    = LEN_WIDTH + 1;

	// numerator u*2^30 < 2^61; quotient <= 2^30, so the top bits start as remainder
	logic [NSTEP:0][2:0][RW-1:0]        rem_p;
	logic [NSTEP:0][2:0][NSTEP-1:0]     num_p;
	logic [NSTEP:0][2:0][QUO_WIDTH-1:0] quo_p;
	logic [NSTEP:0][LEN_WIDTH-1:0]      den_p;
	stnm_tag_t [NSTEP:0]                tag_p;
	logic [NSTEP:0]                     valid_p;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rem_p[0][a] = RW'(u[a] >> 1);
			num_p[0][a] = {u[a][0], {FRAC_ONE{1'b0}}};
			quo_p[0][a] = '0;
		end
		den_p[0]   = len;
		tag_p[0]   = tag_in;
		valid_p[0] = in_valid;
	end

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		always_ff @(posedge clk) begin
			for (int a = 0; a < 3; a++) begin
				logic [RW-1:0] sh;
				sh = {rem_p[k][a][RW-2:0], num_p[k][a][NSTEP-1]};
				if (sh >= RW'(den_p[k])) begin
					rem_p[k+1][a] <= sh - RW'(den_p[k]);
					quo_p[k+1][a] <= {quo_p[k][a][QUO_WIDTH-2:0], 1'b1};
				end else begin
					rem_p[k+1][a] <= sh;
					quo_p[k+1][a] <= {quo_p[k][a][QUO_WIDTH-2:0], 1'b0};
				end
				num_p[k+1][a] <= {num_p[k][a][NSTEP-2:0], 1'b0};
			end
			den_p[k+1] <= den_p[k];
			tag_p[k+1] <= tag_p[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_p[k+1] <= 1'b0;
			else         valid_p[k+1] <= valid_p[k];
		end
	end

	// apply signs, zero the degenerate case
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (tag_p[NSTEP].degen) begin
				unit[a] <= '0;
			end else if (tag_p[NSTEP].neg[a]) begin
				unit[a] <= -$signed(OUT_WIDTH'(quo_p[NSTEP][a]));
			end else begin
				unit[a] <= $signed(OUT_WIDTH'(quo_p[NSTEP][a]));
			end
		end
		degenerate <= tag_p[NSTEP].degen;
		last_out   <= tag_p[NSTEP].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else         out_valid <= valid_p[NSTEP];
	end
endmodule

FILE: rtl/core/sphere_triangle_node_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_triangle_node_map: map a triangle reference node onto the unit sphere
// Each start transfers three vertices (Q15.16) and a node (r,s) in Q1.30.
// The block forms the affine point, block-scales it, takes the integer
// length and divides each axis by it, giving unit_x/y/z in Q1.30.
//
// Usage:
//   Raise start with the fields valid; busy is always low, so a node is
//   taken on every cycle that start is high. One result appears per node
//   with done high for exactly one cycle; the receiver cannot stall.
// Stages from start to done: 2 affine,
//   2 scaling, 2 squares and sum, 32 square-root steps, 31 divide steps,
//   1 output register.
// Throughput: one node per cycle; every stage is a register, the square
//   root and the divider produce one bit per stage.
// Reset: arst_n clears all valid bits; nodes in flight are dropped and
//   done stays low until new nodes arrive.
// A zero-length point gives zeros with degenerate high.
// ----------------------------------------------------------------------------
module sphere_triangle_node_map #(
	parameter int unsigned COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] vertex_a_x,
	input  logic signed [31:0] vertex_a_y,
	input  logic signed [31:0] vertex_a_z,
	input  logic signed [31:0] vertex_b_x,
	input  logic signed [31:0] vertex_b_y,
	input  logic signed [31:0] vertex_b_z,
	input  logic signed [31:0] vertex_c_x,
	input  logic signed [31:0] vertex_c_y,
	input  logic signed [31:0] vertex_c_z,
	input  logic signed [stnm_pkg::REF_WIDTH-1:0] ref_r,
	input  logic signed [stnm_pkg::REF_WIDTH-1:0] ref_s,
	input  logic        last_node,
	output logic        done,
	output logic signed [stnm_pkg::OUT_WIDTH-1:0] unit_x,
	output logic signed [stnm_pkg::OUT_WIDTH-1:0] unit_y,
	output logic signed [stnm_pkg::OUT_WIDTH-1:0] unit_z,
	output logic        degenerate,
	output logic        last_out
);
	import stnm_pkg::*;

	localparam int unsigned Q_WIDTH = REF_WIDTH + 2 + COORD_WIDTH + 2;

	logic signed [2:0][2:0][COORD_WIDTH-1:0] vert;
	logic                                   aff_valid;
	logic signed [2:0][Q_WIDTH-1:0]         aff_q;
	logic                                   aff_last;
	logic                                   scl_valid;
	logic [2:0][U_WIDTH-1:0]                scl_u;
	stnm_tag_t                              scl_tag;
	logic                                   rt_valid;
	logic [2:0][U_WIDTH-1:0]                rt_u;
	stnm_tag_t                              rt_tag;
	logic [LEN_WIDTH-1:0]                   rt_len;
	logic signed [2:0][OUT_WIDTH-1:0]       unit;

	// use the low coordinate bits as two's complement
	assign vert[0][0] = COORD_WIDTH'(vertex_a_x);
	assign vert[0][1] = COORD_WIDTH'(vertex_a_y);
	assign vert[0][2] = COORD_WIDTH'(vertex_a_z);
	assign vert[1][0] = COORD_WIDTH'(vertex_b_x);
	assign vert[1][1] = COORD_WIDTH'(vertex_b_y);
	assign vert[1][2] = COORD_WIDTH'(vertex_b_z);
	assign vert[2][0] = COORD_WIDTH'(vertex_c_x);
	assign vert[2][1] = COORD_WIDTH'(vertex_c_y);
	assign vert[2][2] = COORD_WIDTH'(vertex_c_z);

	// fully pipelined: never hold off a transfer
	assign busy = 1'b0;

	stnm_affine #(.COORD_WIDTH(COORD_WIDTH), .Q_WIDTH(Q_WIDTH)) u_affine (
		.clk, .arst_n,
		.in_valid (start),
		.vert     (vert),
		.ref_r, .ref_s,
		.last_in  (last_node),
		.out_valid(aff_valid),
		.q        (aff_q),
		.last_out (aff_last)
	);

	stnm_scale #(.Q_WIDTH(Q_WIDTH)) u_scale (
		.clk, .arst_n,
		.in_valid (aff_valid),
		.q        (aff_q),
		.last_in  (aff_last),
		.out_valid(scl_valid),
		.u        (scl_u),
		.tag      (scl_tag)
	);

	stnm_sqrt u_sqrt (
		.clk, .arst_n,
		.in_valid (scl_valid),
		.u_in     (scl_u),
		.tag_in   (scl_tag),
		.out_valid(rt_valid),
		.u_out    (rt_u),
		.tag_out  (rt_tag),
		.len      (rt_len)
	);

	stnm_div u_div (
		.clk, .arst_n,
		.in_valid  (rt_valid),
		.u         (rt_u),
		.tag_in    (rt_tag),
		.len       (rt_len),
		.out_valid (done),
		.unit      (unit),
		.degenerate(degenerate),
		.last_out  (last_out)
	);

	assign unit_x = unit[0];
	assign unit_y = unit[1];
	assign unit_z = unit[2];
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sphere_triangle_node_map
// Drives directed and random triangle nodes with random gaps, predicts each
// unit-sphere result in exact wide arithmetic and checks every done cycle
// against the oldest prediction in order.
// ----------------------------------------------------------------------------

typedef struct {
	logic signed [31:0] ux;
	logic signed [31:0] uy;
	logic signed [31:0] uz;
	logic               degen;
	logic               last;
} node_result_t;

class node_scoreboard;
	node_result_t pending[$];
	int           errors;

	function new();
		errors = 0;
	endfunction

	// integer square root of a 64-bit value
	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// predict the projected node and queue it
	function void note_node(logic [31:0] vert[9], logic signed [31:0] r,
			logic signed [31:0] s, logic last);
		logic signed [127:0] q[3];
		logic [127:0]        m[3];
		logic [63:0]         u[3];
		logic [63:0]         sum;
		logic [63:0]         len;
		logic [63:0]         quo;
		logic signed [127:0] wa, wb, wc;
		node_result_t        res;
		int                  blen;
		wa = -(128'(r) + 128'(s));
		wb = (128'sd1 <<< 30) + 128'(r);
		wc = (128'sd1 <<< 30) + 128'(s);
		blen = 0;
		for (int i = 0; i < 3; i++) begin
			q[i] = wa * 128'($signed(vert[i])) + wb * 128'($signed(vert[3 + i]))
				+ wc * 128'($signed(vert[6 + i]));
			m[i] = q[i][127] ? 128'(-q[i]) : 128'(q[i]);
			for (int k = 0; k < 128; k++)
				if (m[i][k] && k + 1 > blen)
					blen = k + 1;
		end
		res.last = last;
		res.degen = (blen == 0);
		res.ux = 0;
		res.uy = 0;
		res.uz = 0;
		if (blen != 0) begin
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if (blen > 30)
					u[i] = 64'(m[i] >> (blen - 30));
				else
					u[i] = 64'(m[i]) << (30 - blen);
				sum = sum + u[i] * u[i];
			end
			len = isqrt(sum);
			for (int i = 0; i < 3; i++) begin
				quo = (u[i] << 30) / len;
				if (q[i][127])
					quo = -quo;
				if (i == 0) res.ux = quo[31:0];
				else if (i == 1) res.uy = quo[31:0];
				else res.uz = quo[31:0];
			end
		end
		pending.push_back(res);
	endfunction

	// compare one result with the oldest prediction
	function void check_result(node_result_t got);
		node_result_t exp_r;
		if (pending.size() == 0) begin
			$error("unexpected result");
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.ux !== exp_r.ux) begin
			$error("unit_x exp %0d got %0d", exp_r.ux, got.ux);
			errors++;
		end
		if (got.uy !== exp_r.uy) begin
			$error("unit_y exp %0d got %0d", exp_r.uy, got.uy);
			errors++;
		end
		if (got.uz !== exp_r.uz) begin
			$error("unit_z exp %0d got %0d", exp_r.uz, got.uz);
			errors++;
		end
		if (got.degen !== exp_r.degen) begin
			$error("degenerate exp %0b got %0b", exp_r.degen, got.degen);
			errors++;
		end
		if (got.last !== exp_r.last) begin
			$error("last_out exp %0b got %0b", exp_r.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;
	localparam int RANDOM_NODES = 1600;
	localparam int LATENCY      = 74;
	localparam int CYCLE_LIMIT  = 400000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic               busy;
	logic signed [31:0] vert[9];
	logic signed [31:0] ref_r = 0;
	logic signed [31:0] ref_s = 0;
	logic               last_node = 0;
	logic               done;
	logic signed [31:0] unit_x, unit_y, unit_z;
	logic               degenerate, last_out;
	int                 cycles = 0;
	node_scoreboard     board;

	initial
		for (int i = 0; i < 9; i++)
			vert[i] = 0;

	always #5 clk = ~clk;

	sphere_triangle_node_map u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vertex_a_x(vert[0]), .vertex_a_y(vert[1]), .vertex_a_z(vert[2]),
		.vertex_b_x(vert[3]), .vertex_b_y(vert[4]), .vertex_b_z(vert[5]),
		.vertex_c_x(vert[6]), .vertex_c_y(vert[7]), .vertex_c_z(vert[8]),
		.ref_r(ref_r), .ref_s(ref_s), .last_node(last_node),
		.done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
		.degenerate(degenerate), .last_out(last_out)
	);

	// check every result transfer and watch the limit
	always @(posedge clk) begin
		node_result_t got;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sphere_triangle_node_map: mismatch");
			$finish;
		end
		if (arst_n && done === 1'b1) begin
			got.ux = unit_x;
			got.uy = unit_y;
			got.uz = unit_z;
			got.degen = degenerate;
			got.last = last_out;
			board.check_result(got);
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)) << 8;
		endcase
	endfunction

	function automatic logic [31:0] rand_ref();
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh40000000 : 32'shc0000000;
			2: return 0;
			default: return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
		endcase
	endfunction

	// idle a random gap, mostly short
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			n = 0;
		repeat (n) begin
			start <= 0;
			@(posedge clk);
		end
	endtask

	// transfer one node, waiting until busy is low at the edge
	task automatic send_node(logic [31:0] v[9], logic [31:0] r, logic [31:0] s, logic last);
		for (int i = 0; i < 9; i++)
			vert[i] <= v[i];
		ref_r <= r;
		ref_s <= s;
		last_node <= last;
		start <= 1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		board.note_node(v, r, s, last);
	endtask

	initial begin
		logic [31:0] v[9];
		logic [31:0] r, s;
		int          wait_cycles;
		board = new();
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero point, extremes, unit node corners, out-of-range refs
		for (int t = 0; t < 20; t++) begin
			for (int i = 0; i < 9; i++)
				case (t % 5)
					0: v[i] = 0;
					1: v[i] = 32'h7fffffff;
					2: v[i] = 32'h80000000;
					3: v[i] = (i % 2) ? 32'h80000000 : 32'h7fffffff;
					default: v[i] = 32'(i + 1) << 16;
				endcase
			case (t / 5)
				0: begin r = 32'shc0000000; s = 32'shc0000000; end
				1: begin r = 32'sh40000000; s = 32'shc0000000; end
				2: begin r = 32'h7fffffff; s = 32'h80000000; end
				default: begin r = 32'h80000000; s = 32'h7fffffff; end
			endcase
			send_node(v, r, s, t[0]);
		end
		// zero from cancellation: only vertex b is nonzero and r = -1, s = 0 give it weight zero
		for (int i = 0; i < 9; i++)
			v[i] = 0;
		v[3] = 32'h00010000;
		send_node(v, 32'shc0000000, 32'sh0, 1'b1);

		for (int n = 0; n < RANDOM_NODES; n++) begin
			idle_gap();
			for (int i = 0; i < 9; i++)
				v[i] = rand_coord();
			if ($urandom_range(0, 15) == 0)
				for (int i = 0; i < 9; i++)
					v[i] = 0;
			send_node(v, rand_ref(), rand_ref(), $urandom_range(0, 1));
		end
		start <= 0;

		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (LATENCY) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("sphere_triangle_node_map: match");
		else
			$display("sphere_triangle_node_map: mismatch");
		$finish;
	end
endmodule
